/* rtl/core/crlc_pkg.sv */
// ----------------------------------------------------------------------------
// crlc_pkg
// Shared types and constants of the color range lookup classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package crlc_pkg;

  localparam int CMD_W     = 2;
  localparam int CHAN_W    = 8;
  localparam int RADIUS_W  = 9;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_CLASSIFY = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS_FIRST  = 2'd0,
    REG_RADIUS_SECOND = 2'd1,
    REG_RADIUS_THIRD  = 2'd2
  } reg_idx_t;

  localparam logic signed [RADIUS_W-1:0] RADIUS_FIRST_RST  = -9'sd3;
  localparam logic signed [RADIUS_W-1:0] RADIUS_SECOND_RST = 9'sd5;
  localparam logic signed [RADIUS_W-1:0] RADIUS_THIRD_RST  = 9'sd5;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MARK = 2'b10
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic classify;
  } ctrl_t;

  typedef struct packed {
    logic last;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/crlc_if.sv */
// ----------------------------------------------------------------------------
// crlc_in_if / crlc_out_if
// Valid/ready channels for commands and classification results.
// ----------------------------------------------------------------------------
`default_nettype none

interface crlc_in_if import crlc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAN_W-1:0] chan_a;
  logic [CHAN_W-1:0] chan_b;
  logic [CHAN_W-1:0] chan_c;

  modport source (output valid, cmd, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, cmd, chan_a, chan_b, chan_c, output ready);
endinterface

interface crlc_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

`default_nettype wire

/* rtl/core/crlc_range.sv */
// ----------------------------------------------------------------------------
// crlc_range
// Table index, marking start and marking count for one channel.
// ----------------------------------------------------------------------------
`default_nettype none

module crlc_range import crlc_pkg::*; #(
  parameter int IW = 8
) (
  input  wire logic [CHAN_W-1:0]          chan,
  input  wire logic signed [RADIUS_W-1:0] radius,
  output logic [IW-1:0]                   idx,
  output logic [IW-1:0]                   start,
  output logic [IW:0]                     count
);

  localparam int SW = ((IW > RADIUS_W) ? IW : RADIUS_W) + 3;
  localparam int TW = 1 << IW;
  localparam logic signed [SW-1:0] TOP  = SW'(TW - 1);
  localparam logic signed [SW-1:0] FULL = SW'(TW);

  logic [SW-1:0]        chan_w;
  logic signed [SW-1:0] c_s;
  logic signed [SW-1:0] r_s;
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] mag;
  logic signed [SW-1:0] span;
  logic signed [SW-1:0] st;
  logic signed [SW-1:0] cnt;

  always_comb begin
    chan_w = SW'(chan);
    idx    = chan_w[IW-1:0];
    c_s    = signed'(SW'(idx));
    r_s    = SW'(radius);
    lo     = c_s - r_s;
    hi     = c_s + r_s;
    mag    = -r_s;
    span   = (mag <<< 1) + SW'(1);
    st     = '0;
    cnt    = FULL;
    if (r_s >= 0) begin
      if (lo < 0) begin
        lo = '0;
      end
      if (hi > TOP) begin
        hi = TOP;
      end
      st  = lo;
      cnt = hi - lo + SW'(1);
    end else if (span < FULL) begin
      st  = c_s - mag;
      cnt = span;
    end
    start = st[IW-1:0];
    count = cnt[IW:0];
  end

endmodule

`default_nettype wire

/* rtl/core/crlc_datapath.sv */
// ----------------------------------------------------------------------------
// crlc_datapath
// Radius registers, membership tables, mark and clear sequencer, result.
// ----------------------------------------------------------------------------
`default_nettype none

module crlc_datapath import crlc_pkg::*; #(
  parameter int IW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [RADIUS_W-1:0]  cfg_wdata,
  input  wire logic [CHAN_W-1:0]    chan_a,
  input  wire logic [CHAN_W-1:0]    chan_b,
  input  wire logic [CHAN_W-1:0]    chan_c,
  input  wire ctrl_t                ctrl,
  output stat_t                     stat,
  output logic                      matched
);

  localparam int TW = 1 << IW;
  localparam logic [IW:0] FULL_CNT = {1'b1, {IW{1'b0}}};

  logic signed [RADIUS_W-1:0] rad_a_r, rad_b_r, rad_c_r;
  logic          tbl_a_r [TW];
  logic          tbl_b_r [TW];
  logic          tbl_c_r [TW];
  logic [IW-1:0] idx_a, idx_b, idx_c;
  logic [IW-1:0] st_a, st_b, st_c;
  logic [IW:0]   cn_a, cn_b, cn_c;
  logic [IW-1:0] st_a_r, st_b_r, st_c_r;
  logic [IW:0]   cn_a_r, cn_b_r, cn_c_r;
  logic [IW:0]   max_ab, max_nxt, max_r;
  logic [IW:0]   k_r, k_inc;
  logic [IW-1:0] wa, wb, wc;
  logic          fill_r;
  logic          matched_r;

  crlc_range #(.IW(IW)) u_rng_a (
    .chan(chan_a), .radius(rad_a_r), .idx(idx_a), .start(st_a), .count(cn_a)
  );
  crlc_range #(.IW(IW)) u_rng_b (
    .chan(chan_b), .radius(rad_b_r), .idx(idx_b), .start(st_b), .count(cn_b)
  );
  crlc_range #(.IW(IW)) u_rng_c (
    .chan(chan_c), .radius(rad_c_r), .idx(idx_c), .start(st_c), .count(cn_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_a_r <= RADIUS_FIRST_RST;
      rad_b_r <= RADIUS_SECOND_RST;
      rad_c_r <= RADIUS_THIRD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RADIUS_FIRST:  rad_a_r <= cfg_wdata;
        REG_RADIUS_SECOND: rad_b_r <= cfg_wdata;
        REG_RADIUS_THIRD:  rad_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    max_ab  = (cn_a > cn_b) ? cn_a : cn_b;
    max_nxt = (cn_c > max_ab) ? cn_c : max_ab;
    k_inc   = k_r + 1'b1;
    wa      = st_a_r + k_r[IW-1:0];
    wb      = st_b_r + k_r[IW-1:0];
    wc      = st_c_r + k_r[IW-1:0];
    stat.last = (k_inc == max_r);
  end

  // clear walks every entry writing zero; add walks its spans writing one
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      st_a_r <= '0;
      st_b_r <= '0;
      st_c_r <= '0;
      cn_a_r <= FULL_CNT;
      cn_b_r <= FULL_CNT;
      cn_c_r <= FULL_CNT;
      max_r  <= FULL_CNT;
      k_r    <= '0;
      fill_r <= 1'b0;
    end else if (ctrl.load) begin
      st_a_r <= st_a;
      st_b_r <= st_b;
      st_c_r <= st_c;
      cn_a_r <= cn_a;
      cn_b_r <= cn_b;
      cn_c_r <= cn_c;
      max_r  <= max_nxt;
      k_r    <= '0;
      fill_r <= 1'b1;
    end else if (ctrl.step) begin
      k_r <= k_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      if (k_r < cn_a_r) begin
        tbl_a_r[wa] <= fill_r;
      end
      if (k_r < cn_b_r) begin
        tbl_b_r[wb] <= fill_r;
      end
      if (k_r < cn_c_r) begin
        tbl_c_r[wc] <= fill_r;
      end
    end
    if (ctrl.classify) begin
      matched_r <= tbl_a_r[idx_a] & tbl_b_r[idx_b] & tbl_c_r[idx_c];
    end
  end

  assign matched = matched_r;

endmodule

`default_nettype wire

/* rtl/core/crlc_ctrl.sv */
// ----------------------------------------------------------------------------
// crlc_ctrl
// Command decode, mark sequencing and result register control.
// ----------------------------------------------------------------------------
`default_nettype none

module crlc_ctrl import crlc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_cmd,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire stat_t            stat,
  output ctrl_t                 ctrl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
    accept    = in_valid && in_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_CLEAR) begin
            ctrl.clear = 1'b1;
            state_nxt  = ST_MARK;
          end else if (in_cmd == CMD_ADD) begin
            ctrl.load = 1'b1;
            state_nxt = ST_MARK;
          end else if (in_cmd == CMD_CLASSIFY) begin
            ctrl.classify = 1'b1;
          end
        end
      end
      ST_MARK: begin
        ctrl.step = 1'b1;
        if (stat.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (ctrl.classify) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // reset enters the walk so the tables are wiped before the first command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_MARK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/color_range_lut_classifier.sv */
// ----------------------------------------------------------------------------
// color_range_lut_classifier
// Three per-channel membership tables with clear, range add and classify.
//
//   channel  direction  payload                       handshake
//   in_ch    sink       cmd, chan_a, chan_b, chan_c   valid/ready
//   out_ch   source     matched (classify only)       valid/ready
//   cfg_*    write      cfg_idx, cfg_wdata            cfg_we
//
// Classify results are registered; classify transfers go back to back while out_ch is ready.
// Add walks the widest span (span up to 2^CHANNEL_BITS) and clear walks every
// entry: the sequencer writes one entry per table per cycle.
// After reset a clearing pass wipes the tables; in_ch stalls meanwhile.
// The result sits in an output register; in_ch stalls while it is held
// and out_ch is not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module color_range_lut_classifier import crlc_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  crlc_in_if.sink                   in_ch,
  crlc_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [RADIUS_W-1:0]  cfg_wdata
);

  ctrl_t ctrl;
  stat_t stat;

  crlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  crlc_datapath #(.IW(CHANNEL_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .chan_a    (in_ch.chan_a),
    .chan_b    (in_ch.chan_b),
    .chan_c    (in_ch.chan_c),
    .ctrl      (ctrl),
    .stat      (stat),
    .matched   (out_ch.matched)
  );

endmodule

`default_nettype wire
